// ----- sv/dfts_pkg.sv -----
package dfts_pkg;

	localparam int unsigned FREQ_LIMIT_DEF = 200;

	localparam int unsigned CNT_W   = 8;
	localparam int unsigned SPEED_W = 13;
	localparam int unsigned DUTY_W  = 9;
	localparam int unsigned TGT_W   = 13;
	localparam int unsigned RUN_W   = 2;
	localparam int unsigned IDX_W   = 2;

	localparam int unsigned IN_DATA_W  = 8;
	localparam int unsigned IN_USER_W  = 2;
	localparam int unsigned OUT_DATA_W = 48;

	localparam logic [TGT_W-1:0] TGT_MIN = 13'd1000;
	localparam logic [TGT_W-1:0] TGT_MAX = 13'd5000;

	localparam logic [SPEED_W:0] BAND_FINE   = 14'd30;
	localparam logic [SPEED_W:0] BAND_MID    = 14'd240;
	localparam logic [SPEED_W:0] BAND_COARSE = 14'd510;

	localparam logic [DUTY_W-1:0] DUTY_MAX       = 9'd400;
	localparam logic [DUTY_W-1:0] DUTY_STEP_HIGH = 9'd384;
	localparam logic [DUTY_W-1:0] STEP_COARSE    = 9'd16;
	localparam logic [DUTY_W-1:0] STEP_MID       = 9'd8;
	localparam logic [DUTY_W-1:0] STEP_FINE      = 9'd1;
	localparam logic [DUTY_W-1:0] FLOOR_COARSE   = 9'd32;
	localparam logic [DUTY_W-1:0] FLOOR_MID      = 9'd8;
	localparam logic [DUTY_W-1:0] FLOOR_FINE     = 9'd2;

	typedef enum logic [1:0] {
		OP_PULSE = 2'd0,
		OP_CLEAR = 2'd1,
		OP_LATCH = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	localparam logic [IDX_W-1:0] REG_TARGET_A = 2'd0;
	localparam logic [IDX_W-1:0] REG_TARGET_B = 2'd1;
	localparam logic [IDX_W-1:0] REG_RUN_MASK = 2'd2;

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic              wr;
	} dfts_step_t;

endpackage

// ----- sv/dfts_step.sv -----
module dfts_step (
	input  logic [dfts_pkg::TGT_W-1:0]   target,
	input  logic [dfts_pkg::SPEED_W-1:0] speed,
	input  logic [dfts_pkg::DUTY_W-1:0]  duty,
	output dfts_pkg::dfts_step_t         result
);
	import dfts_pkg::*;

	logic [SPEED_W:0] t;
	logic [SPEED_W:0] s;
	logic [DUTY_W-1:0] d;

	always_comb begin
		if (target < TGT_MIN) begin
			t = {1'b0, TGT_MIN};
		end else if (target > TGT_MAX) begin
			t = {1'b0, TGT_MAX};
		end else begin
			t = {1'b0, target};
		end
	end

	assign s = {1'b0, speed};

	// dead band of +-30 rpm, wider steps further out
	always_comb begin
		d = duty;
		result.wr = 1'b1;
		if (s > t + BAND_FINE) begin
			if (s > t + BAND_COARSE) begin
				if (duty > FLOOR_COARSE) d = duty - STEP_COARSE;
			end else if (s > t + BAND_MID) begin
				if (duty > FLOOR_MID) d = duty - STEP_MID;
			end else begin
				if (duty > FLOOR_FINE) d = duty - STEP_FINE;
			end
		end else if (s + BAND_FINE < t) begin
			if (s + BAND_COARSE < t) begin
				if (duty < DUTY_STEP_HIGH) d = duty + STEP_COARSE;
			end else if (s + BAND_MID < t) begin
				if (duty < DUTY_STEP_HIGH) d = duty + STEP_MID;
			end else begin
				if (duty < DUTY_MAX) d = duty + STEP_FINE;
			end
		end else begin
			result.wr = 1'b0;
		end
		result.duty = d;
	end

endmodule

// ----- sv/dual_fan_tach_speed_regulator.sv -----
// channel | direction | handshake                    | payload
// s_axis  | in        | s_axis_tvalid/s_axis_tready  | tdata fan_select, tuser op
// m_axis  | out       | m_axis_tvalid/m_axis_tready  | tdata duty, speed, pwm_write
// cfg     | in        | cfg_valid/cfg_ready          | cfg_index, cfg_data
//
// every item gives one result, registered in the cycle after it is accepted; a new item can
// be taken each cycle, limited only by the single output register.
// s_axis_tready drops only while a result is held and m_axis_tready is low.
// arst_n clears all counters, frequencies, speeds and duties and loads the
// register reset values; cfg_ready is always high.
module dual_fan_tach_speed_regulator #(
	parameter int unsigned FREQ_LIMIT = dfts_pkg::FREQ_LIMIT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [0] fan_select, [7:1] zero
	input  logic [dfts_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// [1:0] op
	input  logic [dfts_pkg::IN_USER_W-1:0]     s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [8:0] duty_a, [17:9] duty_b, [30:18] speed_a, [43:31] speed_b,
	// [44] pwm_write_a, [45] pwm_write_b, [47:46] zero
	output logic [dfts_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [dfts_pkg::IDX_W-1:0]         cfg_index,
	input  logic [dfts_pkg::TGT_W-1:0]         cfg_data
);
	import dfts_pkg::*;

	localparam logic [CNT_W-1:0] FreqLim = CNT_W'(FREQ_LIMIT);
	localparam logic [CNT_W-1:0] CntMax  = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] CntOne  = CNT_W'(1);

	logic [TGT_W-1:0]   tgt_q [2];
	logic [RUN_W-1:0]   run_q;
	logic [CNT_W-1:0]   pulse_q [2];
	logic [CNT_W-1:0]   freq_q [2];
	logic [SPEED_W-1:0] speed_q [2];
	logic [DUTY_W-1:0]  duty_q [2];
	logic               m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	logic [CNT_W-1:0]   pulse_d [2];
	logic [CNT_W-1:0]   freq_d [2];
	logic [SPEED_W-1:0] speed_d [2];
	logic [DUTY_W-1:0]  duty_d [2];
	logic [DUTY_W-1:0]  duty_in [2];
	logic [SPEED_W-1:0] speed_new [2];
	logic [1:0]         wr_d;
	logic [1:0]         running;
	logic [1:0]         running_cfg;
	logic [TGT_W-1:0]   tgt_cfg [2];
	logic [RUN_W-1:0]   run_cfg;
	dfts_step_t         step [2];
	op_t                op;
	logic               sel;
	logic               in_acc;
	logic               cfg_acc;

	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign cfg_acc       = cfg_valid;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	assign op  = op_t'(s_axis_tuser);
	assign sel = s_axis_tdata[0];

	for (genvar k = 0; k < 2; k++) begin : g_fan
		assign running[k]   = run_q[k] && (tgt_q[k] != '0);
		assign duty_in[k]   = running[k] ? duty_q[k] : '0;
		// 30*f as 32*f - 2*f
		assign speed_new[k] = SPEED_W'(({5'b0, freq_q[k]} << 5) - ({5'b0, freq_q[k]} << 1));

		dfts_step u_step (
			.target (tgt_q[k]),
			.speed  (speed_new[k]),
			.duty   (duty_in[k]),
			.result (step[k])
		);

		assign running_cfg[k] = run_cfg[k] && (tgt_cfg[k] != '0);
	end

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			pulse_d[k] = pulse_q[k];
			freq_d[k]  = freq_q[k];
			speed_d[k] = speed_q[k];
			duty_d[k]  = duty_in[k];
			wr_d[k]    = 1'b0;
		end
		case (op)
			OP_PULSE: begin
				if (pulse_q[sel] < CntMax) pulse_d[sel] = pulse_q[sel] + CntOne;
			end
			OP_CLEAR: begin
				for (int k = 0; k < 2; k++) pulse_d[k] = '0;
			end
			OP_LATCH: begin
				for (int k = 0; k < 2; k++) begin
					freq_d[k]  = (pulse_q[k] > FreqLim) ? FreqLim : pulse_q[k];
					pulse_d[k] = '0;
				end
			end
			OP_TICK: begin
				for (int k = 0; k < 2; k++) begin
					if (running[k]) begin
						speed_d[k] = speed_new[k];
						duty_d[k]  = step[k].duty;
						wr_d[k]    = step[k].wr;
					end
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		tgt_cfg[0] = tgt_q[0];
		tgt_cfg[1] = tgt_q[1];
		run_cfg    = run_q;
		case (cfg_index)
			REG_TARGET_A: tgt_cfg[0] = cfg_data;
			REG_TARGET_B: tgt_cfg[1] = cfg_data;
			REG_RUN_MASK: run_cfg    = cfg_data[RUN_W-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q[0]   <= TGT_MIN;
			tgt_q[1]   <= TGT_MIN;
			run_q      <= '1;
			pulse_q[0] <= '0;
			pulse_q[1] <= '0;
			freq_q[0]  <= '0;
			freq_q[1]  <= '0;
			speed_q[0] <= '0;
			speed_q[1] <= '0;
			duty_q[0]  <= '0;
			duty_q[1]  <= '0;
		end else begin
			if (in_acc) begin
				for (int k = 0; k < 2; k++) begin
					pulse_q[k] <= pulse_d[k];
					freq_q[k]  <= freq_d[k];
					speed_q[k] <= speed_d[k];
				end
			end
			if (cfg_acc) begin
				tgt_q[0] <= tgt_cfg[0];
				tgt_q[1] <= tgt_cfg[1];
				run_q    <= run_cfg;
			end
			// a fan that the write stops drops its duty at once
			for (int k = 0; k < 2; k++) begin
				if (cfg_acc && !running_cfg[k]) begin
					duty_q[k] <= '0;
				end else if (in_acc) begin
					duty_q[k] <= duty_d[k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (in_acc) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			m_data_q <= {2'b00, wr_d[1], wr_d[0], speed_d[1], speed_d[0],
				duty_d[1], duty_d[0]};
		end
	end

endmodule

// ----- tb/sv/dual_fan_tach_speed_regulator_test.sv -----
module dual_fan_tach_speed_regulator_test;
	timeunit 1ns;
	timeprecision 1ps;

	import dfts_pkg::*;

	localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		op_t  op;
		logic sel;
	} tach_item_t;

	// packed msb first, so duty_a lands in the low bits of tdata
	typedef struct packed {
		logic               wr_b;
		logic               wr_a;
		logic [SPEED_W-1:0] speed_b;
		logic [SPEED_W-1:0] speed_a;
		logic [DUTY_W-1:0]  duty_b;
		logic [DUTY_W-1:0]  duty_a;
	} fan_status_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// [0] fan_select, [7:1] zero
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	// [1:0] op
	logic [IN_USER_W-1:0]  s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// [8:0] duty_a, [17:9] duty_b, [30:18] speed_a, [43:31] speed_b,
	// [44] pwm_write_a, [45] pwm_write_b, [47:46] zero
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [IDX_W-1:0]      cfg_index = '0;
	logic [TGT_W-1:0]      cfg_data = '0;

	dual_fan_tach_speed_regulator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// regulator state as seen from outside
	logic [CNT_W-1:0]   pulse_cnt [2];
	logic [CNT_W-1:0]   win_freq [2];
	logic [SPEED_W-1:0] fan_rpm [2];
	logic [DUTY_W-1:0]  duty [2];
	logic [TGT_W-1:0]   target [2];
	logic [RUN_W-1:0]   run_bits;

	tach_item_t  pending [$];
	fan_status_t expected [$];
	tach_item_t  cur_item;
	fan_status_t got;
	fan_status_t want;
	int          mismatches = 0;
	int          phase_items;
	int          src_gap;
	int          sink_gap;
	logic        src_burst = 1'b0;
	logic        sink_burst = 1'b0;

	initial begin
		pulse_cnt = '{default: '0};
		win_freq  = '{default: '0};
		fan_rpm   = '{default: '0};
		duty      = '{default: '0};
		target    = '{13'd1000, 13'd1000};
		run_bits  = 2'b11;
	end

	function automatic int clamp_target(int t);
		if (t < 1000) return 1000;
		if (t > 5000) return 5000;
		return t;
	endfunction

	function automatic logic fan_on(int k);
		return run_bits[k] && (target[k] != '0);
	endfunction

	function automatic void hold_stopped();
		for (int k = 0; k < 2; k++)
			if (!fan_on(k)) duty[k] = '0;
	endfunction

	// dead-band step toward the target, returns 1 when the compare is written
	function automatic logic step_duty(int k);
		int t;
		int s;
		int d;
		t = clamp_target(target[k]);
		s = fan_rpm[k];
		d = duty[k];
		if (s > t + 30) begin
			if (s > t + 510) begin
				if (d > 32) d -= 16;
			end else if (s > t + 240) begin
				if (d > 8) d -= 8;
			end else if (d > 2) begin
				d -= 1;
			end
		end else if (s + 30 < t) begin
			if (s + 510 < t) begin
				if (d < 384) d += 16;
			end else if (s + 240 < t) begin
				if (d < 384) d += 8;
			end else if (d < 400) begin
				d += 1;
			end
		end else begin
			return 1'b0;
		end
		duty[k] = DUTY_W'(d);
		return 1'b1;
	endfunction

	function automatic fan_status_t predict_status(tach_item_t it);
		fan_status_t st;
		logic [1:0]  wr;
		wr = 2'b00;
		hold_stopped();
		case (it.op)
			OP_PULSE: begin
				if (pulse_cnt[it.sel] != 8'd255) pulse_cnt[it.sel] = pulse_cnt[it.sel] + 8'd1;
			end
			OP_CLEAR: begin
				pulse_cnt[0] = '0;
				pulse_cnt[1] = '0;
			end
			OP_LATCH: begin
				for (int k = 0; k < 2; k++) begin
					win_freq[k] = (pulse_cnt[k] > FREQ_LIMIT_DEF) ? CNT_W'(FREQ_LIMIT_DEF)
						: pulse_cnt[k];
					pulse_cnt[k] = '0;
				end
			end
			default: begin
				for (int k = 0; k < 2; k++) begin
					if (fan_on(k)) begin
						fan_rpm[k] = SPEED_W'(30 * int'(win_freq[k]));
						wr[k] = step_duty(k);
					end
				end
			end
		endcase
		st.duty_a  = duty[0];
		st.duty_b  = duty[1];
		st.speed_a = fan_rpm[0];
		st.speed_b = fan_rpm[1];
		st.wr_a    = wr[0];
		st.wr_b    = wr[1];
		return st;
	endfunction

	function automatic void apply_reg(logic [IDX_W-1:0] idx, logic [TGT_W-1:0] val);
		case (idx)
			REG_TARGET_A: target[0] = val;
			REG_TARGET_B: target[1] = val;
			REG_RUN_MASK: run_bits = val[RUN_W-1:0];
			default: return;
		endcase
		hold_stopped();
	endfunction

	function automatic int next_gap(logic burst);
		int r;
		if (burst) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 10);
		return $urandom_range(12, 40);
	endfunction

	function automatic void note_mismatch(string msg);
		mismatches++;
		if (mismatches <= 10) $display("%s", msg);
	endfunction

	function automatic void queue_item(op_t op, logic sel);
		tach_item_t it;
		it.op  = op;
		it.sel = sel;
		pending.push_back(it);
		phase_items++;
	endfunction

	// source side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
			src_gap = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected.push_back(predict_status(cur_item));
				if ($urandom_range(0, 119) == 0) src_burst = !src_burst;
				src_gap = next_gap(src_burst);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (pending.size() != 0) begin
					cur_item = pending.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {{(IN_DATA_W-1){1'b0}}, cur_item.sel};
					s_axis_tuser  <= cur_item.op;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// sink side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_gap = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = fan_status_t'(m_axis_tdata[$bits(fan_status_t)-1:0]);
				if (expected.size() == 0) begin
					note_mismatch($sformatf("unexpected status item %h", m_axis_tdata));
				end else begin
					want = expected.pop_front();
					if (got.duty_a !== want.duty_a || got.duty_b !== want.duty_b ||
					    got.speed_a !== want.speed_a || got.speed_b !== want.speed_b ||
					    got.wr_a !== want.wr_a || got.wr_b !== want.wr_b)
						note_mismatch($sformatf({"status mismatch: expected duty %0d/%0d ",
							"speed %0d/%0d write %b%b, got duty %0d/%0d speed %0d/%0d write %b%b"},
							want.duty_a, want.duty_b, want.speed_a, want.speed_b,
							want.wr_a, want.wr_b, got.duty_a, got.duty_b,
							got.speed_a, got.speed_b, got.wr_a, got.wr_b));
				end
				if ($urandom_range(0, 119) == 0) sink_burst = !sink_burst;
				sink_gap = next_gap(sink_burst);
			end else if (m_axis_tready && !sink_burst && $urandom_range(0, 15) == 0) begin
				sink_gap = next_gap(1'b0);
			end
			if (sink_gap > 0) begin
				sink_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic wait_drained();
		do @(negedge clk);
		while (pending.size() != 0 || s_axis_tvalid || expected.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [TGT_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_reg(idx, val);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// pulse count that puts the fan near, above or below its target
	function automatic int pick_count(int t_eff, logic on);
		int base;
		int off;
		int c;
		if (!on) return $urandom_range(0, 20);
		if ($urandom_range(0, 19) == 0) return $urandom_range(0, 255);
		base = (t_eff + 15) / 30;
		case ($urandom_range(0, 3))
			0: off = $urandom_range(0, 1);
			1: off = $urandom_range(2, 7);
			2: off = $urandom_range(9, 16);
			default: off = $urandom_range(18, 40);
		endcase
		c = $urandom_range(0, 1) ? base + off : base - off;
		if (c < 0) c = 0;
		if (c > 255) c = 255;
		return c;
	endfunction

	// one measurement window: pulses, latch, then a run of ticks
	task automatic add_window(int ca, int cb);
		int n;
		if ($urandom_range(0, 3) == 0) queue_item(OP_CLEAR, 1'($urandom));
		while (ca > 0 || cb > 0) begin
			if (cb == 0 || (ca > 0 && $urandom_range(0, 1) == 0)) begin
				queue_item(OP_PULSE, 1'b0);
				ca--;
			end else begin
				queue_item(OP_PULSE, 1'b1);
				cb--;
			end
			if ($urandom_range(0, 199) == 0) queue_item(op_t'($urandom_range(0, 3)), 1'($urandom));
		end
		queue_item(OP_LATCH, 1'($urandom));
		n = $urandom_range(1, 24);
		repeat (n) begin
			queue_item(OP_TICK, 1'($urandom));
			if ($urandom_range(0, 15) == 0) queue_item(OP_PULSE, 1'($urandom));
		end
	endtask

	task automatic run_phase(int ta, int tgtb, logic [1:0] mask, int budget, logic saturate);
		int ea;
		int eb;
		logic on_a;
		logic on_b;
		wait_drained();
		write_reg(REG_TARGET_A, TGT_W'(ta));
		write_reg(REG_TARGET_B, TGT_W'(tgtb));
		write_reg(REG_RUN_MASK, {11'($urandom), mask});
		if ($urandom_range(0, 1)) write_reg(REG_UNUSED, TGT_W'($urandom));
		ea = clamp_target(ta);
		eb = clamp_target(tgtb);
		on_a = mask[0] && (ta != 0);
		on_b = mask[1] && (tgtb != 0);
		phase_items = 0;
		// counter runs into its ceiling
		if (saturate) add_window(256 + $urandom_range(0, 6), pick_count(eb, on_b));
		while (phase_items < budget) add_window(pick_count(ea, on_a), pick_count(eb, on_b));
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		queue_item(OP_PULSE, 1'b0);
		queue_item(OP_PULSE, 1'b1);
		queue_item(OP_PULSE, 1'b1);
		queue_item(OP_LATCH, 1'b0);
		queue_item(OP_TICK, 1'b1);
		queue_item(OP_CLEAR, 1'b1);
		queue_item(OP_PULSE, 1'b0);
		queue_item(OP_CLEAR, 1'b0);
		queue_item(OP_LATCH, 1'b1);
		queue_item(OP_TICK, 1'b0);
		queue_item(OP_TICK, 1'b1);
		wait_drained();
		// out of range index is dropped, zero target stops fan one at once
		write_reg(REG_UNUSED, 13'h1fff);
		write_reg(REG_TARGET_A, 13'd0);
		queue_item(OP_TICK, 1'b0);
		queue_item(OP_PULSE, 1'b0);
		queue_item(OP_LATCH, 1'b0);
		queue_item(OP_TICK, 1'b1);
		wait_drained();
		write_reg(REG_TARGET_A, 13'd1);
		write_reg(REG_RUN_MASK, 13'h1ffe);
		queue_item(OP_TICK, 1'b0);
		queue_item(OP_TICK, 1'b1);
		wait_drained();
		write_reg(REG_RUN_MASK, 13'd3);
		queue_item(OP_TICK, 1'b0);
		queue_item(OP_TICK, 1'b1);
		queue_item(OP_PULSE, 1'b1);
		queue_item(OP_LATCH, 1'b0);
		queue_item(OP_TICK, 1'b0);

		run_phase(1000, 1000, 2'b11, 120, 1'b1);
		run_phase(3000, 1500, 2'b11, 120, 1'b0);
		run_phase(0, 5000, 2'b11, 120, 1'b0);
		run_phase(999, 8191, 2'b10, 120, 1'b0);
		run_phase(1, 4096, 2'b01, 120, 1'b0);
		run_phase(5000, 0, 2'b11, 120, 1'b0);
		run_phase($urandom_range(0, 8191), $urandom_range(0, 6000), 2'($urandom), 120, 1'b0);
		run_phase(1000, 2000, 2'b11, 120, 1'b0);
		run_phase(2000, 1000, 2'b00, 40, 1'b0);

		wait_drained();
		repeat (5) @(posedge clk);
		if (expected.size() != 0)
			note_mismatch($sformatf("%0d status items never arrived", expected.size()));
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#8ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
